// File: src/tgad_pkg.sv
// Shared types and constants for the TGA image stream decoder.
package tgad_pkg;

	localparam logic [7:0] TGA_TYPE_RAW = 8'd2;
	localparam logic [7:0] TGA_TYPE_RLE = 8'd10;
	localparam logic [7:0] BPP_24       = 8'd24;
	localparam logic [7:0] BPP_32       = 8'd32;
	localparam logic [7:0] RUN_FLAG     = 8'd128;
	localparam logic [7:0] RUN_BIAS     = 8'd127;
	localparam logic [4:0] HDR_TYPE_IDX = 5'd2;
	localparam logic [4:0] HDR_FIX_LEN  = 5'd12;
	localparam logic [4:0] HDR_W_LO     = 5'd12;
	localparam logic [4:0] HDR_W_HI     = 5'd13;
	localparam logic [4:0] HDR_H_LO     = 5'd14;
	localparam logic [4:0] HDR_H_HI     = 5'd15;
	localparam logic [4:0] HDR_BPP      = 5'd16;

	localparam logic SWAP_RESET = 1'b1;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_HEADER    = 2'd0,
		ERR_SIZE      = 2'd1,
		ERR_OVERFLOW  = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_PACKET = 3'd2,
		PH_PIXEL  = 3'd3,
		PH_DONE   = 3'd4,
		PH_ERROR  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  error_code;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        is_compressed;
		logic        has_alpha;
		logic [7:0]  chan0;
		logic [7:0]  chan1;
		logic [7:0]  chan2;
		logic [7:0]  repeat_count;
		logic        image_done;
	} tgad_result_t;

	// Handshake between the parser and the stages around it.
	typedef struct packed {
		logic fire;        // stage-1 item is consumed this cycle
		logic has_result;  // stage-1 item produces a result
	} tgad_ctrl_t;

endpackage

// File: src/tgad_in_stage.sv
// Input register stage: captures one byte item and holds it until the parser consumes it.
module tgad_in_stage
	import tgad_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       file_start,
	input  logic [7:0] data_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic       file_start_s1,
	output logic [7:0] data_byte_s1
);

	logic accept;

	assign in_stall = valid_s1 & ~advance;
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			file_start_s1 <= file_start;
			data_byte_s1  <= data_byte;
		end
	end

endmodule

// File: src/tgad_parser.sv
// Header and pixel parser: decoder state plus the per-byte next-state and result logic.
module tgad_parser
	import tgad_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         swap_to_rgb,
	input  logic         fire,
	input  logic         file_start_s1,
	input  logic [7:0]   data_byte_s1,
	output logic         has_result,
	output tgad_result_t result
);

	phase_t      phase_q, phase_d;
	logic [4:0]  byte_index_q, byte_index_d;
	logic        compressed_q, compressed_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic        four_bytes_q, four_bytes_d;
	logic [31:0] pixels_left_q, pixels_left_d;
	logic        packet_raw_q, packet_raw_d;
	logic [7:0]  packet_left_q, packet_left_d;
	logic [23:0] colour_q, colour_d;

	logic [7:0]  b;
	logic [4:0]  last_idx;
	logic [7:0]  bpp;

	assign b = data_byte_s1;

	always_comb begin
		phase_d       = phase_q;
		byte_index_d  = byte_index_q;
		compressed_d  = compressed_q;
		width_d       = width_q;
		height_d      = height_q;
		four_bytes_d  = four_bytes_q;
		pixels_left_d = pixels_left_q;
		packet_raw_d  = packet_raw_q;
		packet_left_d = packet_left_q;
		colour_d      = colour_q;
		has_result    = 1'b0;
		result        = '0;
		last_idx      = 5'd2;
		bpp           = 8'd0;

		// start of file wipes the parser before the byte is looked at
		if (file_start_s1) begin
			phase_d       = PH_HEADER;
			byte_index_d  = '0;
			compressed_d  = 1'b0;
			width_d       = '0;
			height_d      = '0;
			four_bytes_d  = 1'b0;
			pixels_left_d = '0;
			packet_raw_d  = 1'b0;
			packet_left_d = '0;
			colour_d      = '0;
		end

		case (phase_d)
			PH_HEADER: begin
				byte_index_d = byte_index_d + 5'd1;
				if (byte_index_d - 5'd1 == HDR_TYPE_IDX) begin
					if (b == TGA_TYPE_RAW) begin
						compressed_d = 1'b0;
					end else if (b == TGA_TYPE_RLE) begin
						compressed_d = 1'b1;
					end else begin
						has_result        = 1'b1;
						result.kind       = KIND_ERROR;
						result.error_code = ERR_HEADER;
						phase_d           = PH_ERROR;
					end
				end else if (byte_index_d - 5'd1 < HDR_FIX_LEN) begin
					if (b != 8'd0) begin
						has_result        = 1'b1;
						result.kind       = KIND_ERROR;
						result.error_code = ERR_HEADER;
						phase_d           = PH_ERROR;
					end
				end else if (byte_index_d - 5'd1 == HDR_W_LO) begin
					width_d[7:0] = b;
				end else if (byte_index_d - 5'd1 == HDR_W_HI) begin
					width_d[15:8] = b;
				end else if (byte_index_d - 5'd1 == HDR_H_LO) begin
					height_d[7:0] = b;
				end else if (byte_index_d - 5'd1 == HDR_H_HI) begin
					height_d[15:8] = b;
				end else if (byte_index_d - 5'd1 == HDR_BPP) begin
					colour_d = {16'd0, b};
				end else begin
					// descriptor byte: accept or reject the header
					bpp = colour_d[7:0];
					has_result = 1'b1;
					if (width_d == 16'd0 || height_d == 16'd0 ||
					    (bpp != BPP_24 && bpp != BPP_32)) begin
						result.kind       = KIND_ERROR;
						result.error_code = ERR_SIZE;
						phase_d           = PH_ERROR;
					end else begin
						four_bytes_d  = (bpp == BPP_32);
						pixels_left_d = width_d * height_d;
						colour_d      = '0;
						byte_index_d  = '0;
						packet_left_d = '0;
						packet_raw_d  = 1'b0;
						phase_d       = compressed_d ? PH_PACKET : PH_PIXEL;
						result.kind          = KIND_HEADER;
						result.image_width   = width_d;
						result.image_height  = height_d;
						result.is_compressed = compressed_d;
						result.has_alpha     = (bpp == BPP_32);
					end
				end
			end
			PH_PACKET: begin
				if (b < RUN_FLAG) begin
					packet_raw_d  = 1'b1;
					packet_left_d = b + 8'd1;
				end else begin
					packet_raw_d  = 1'b0;
					packet_left_d = b - RUN_BIAS;
				end
				byte_index_d = '0;
				phase_d      = PH_PIXEL;
			end
			PH_PIXEL: begin
				last_idx = four_bytes_d ? 5'd3 : 5'd2;
				case (byte_index_d)
					5'd0:    colour_d[7:0]   = b;
					5'd1:    colour_d[15:8]  = b;
					5'd2:    colour_d[23:16] = b;
					default: ;
				endcase
				if (byte_index_d < last_idx) begin
					byte_index_d = byte_index_d + 5'd1;
				end else begin
					byte_index_d = '0;
					result.chan0 = swap_to_rgb ? colour_d[23:16] : colour_d[7:0];
					result.chan1 = colour_d[15:8];
					result.chan2 = swap_to_rgb ? colour_d[7:0] : colour_d[23:16];
					has_result   = 1'b1;
					if (!compressed_d || packet_raw_d) begin
						if (pixels_left_d == 32'd0) begin
							result            = '0;
							result.kind       = KIND_ERROR;
							result.error_code = ERR_OVERFLOW;
							phase_d           = PH_ERROR;
						end else begin
							pixels_left_d       = pixels_left_d - 32'd1;
							result.kind         = KIND_PIXEL;
							result.repeat_count = 8'd1;
							if (!compressed_d) begin
								result.image_done = (pixels_left_d == 32'd0);
								if (pixels_left_d == 32'd0) begin
									phase_d = PH_DONE;
								end
							end else begin
								packet_left_d     = packet_left_d - 8'd1;
								result.image_done = (pixels_left_d == 32'd0) &&
								                    (packet_left_d == 8'd0);
								if (packet_left_d == 8'd0) begin
									phase_d = (pixels_left_d == 32'd0) ? PH_DONE : PH_PACKET;
								end
							end
						end
					end else begin
						// run packet: one colour, packet_left copies
						if ({24'd0, packet_left_d} > pixels_left_d) begin
							result            = '0;
							result.kind       = KIND_ERROR;
							result.error_code = ERR_OVERFLOW;
							phase_d           = PH_ERROR;
						end else begin
							pixels_left_d       = pixels_left_d - {24'd0, packet_left_d};
							result.kind         = KIND_PIXEL;
							result.repeat_count = packet_left_d;
							result.image_done   = (pixels_left_d == 32'd0);
							packet_left_d       = '0;
							phase_d = (pixels_left_d == 32'd0) ? PH_DONE : PH_PACKET;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			byte_index_q  <= '0;
			compressed_q  <= 1'b0;
			width_q       <= '0;
			height_q      <= '0;
			four_bytes_q  <= 1'b0;
			pixels_left_q <= '0;
			packet_raw_q  <= 1'b0;
			packet_left_q <= '0;
			colour_q      <= '0;
		end else if (fire) begin
			phase_q       <= phase_d;
			byte_index_q  <= byte_index_d;
			compressed_q  <= compressed_d;
			width_q       <= width_d;
			height_q      <= height_d;
			four_bytes_q  <= four_bytes_d;
			pixels_left_q <= pixels_left_d;
			packet_raw_q  <= packet_raw_d;
			packet_left_q <= packet_left_d;
			colour_q      <= colour_d;
		end
	end

endmodule

// File: src/tgad_out_stage.sv
// Result register: holds one decoded item for the downstream side.
module tgad_out_stage
	import tgad_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  tgad_ctrl_t   ctrl,
	input  tgad_result_t result,
	output logic         slot_free,
	output logic         out_valid,
	input  logic         out_stall,
	output tgad_result_t result_q
);

	logic load;

	assign slot_free = ~out_valid | ~out_stall;
	assign load      = ctrl.fire & ctrl.has_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

// File: src/tga_image_stream_decoder_top.sv
// Top level of the TGA image stream decoder (types 2 and 10, 24/32 bpp).
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | file_start, data_byte
//  out     | out_valid / out_stall| kind, error_code, image_width, image_height,
//          |                      | is_compressed, has_alpha, chan0..chan2,
//          |                      | repeat_count, image_done
//  cfg     | cfg_we               | cfg_wdata (swap_to_rgb)
//
//  One byte item per cycle while out_stall does not back up into in_stall.
//  The input register and the result register form a two-entry buffer, so a byte
//  is taken while a finished result still waits on out_stall.
//  A byte that yields a result holds in the input register only while the result
//  register is full and stalled; bytes that yield nothing never wait.
//  arst_n clears parser state to idle and swap_to_rgb to 1; no clearing pass.
module tga_image_stream_decoder_top
	import tgad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// byte stream in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        file_start,
	input  logic [7:0]  data_byte,
	// decoded items out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [1:0]  error_code,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        is_compressed,
	output logic        has_alpha,
	output logic [7:0]  chan0,
	output logic [7:0]  chan1,
	output logic [7:0]  chan2,
	output logic [7:0]  repeat_count,
	output logic        image_done
);

	logic         swap_q;
	logic         valid_s1;
	logic         file_start_s1;
	logic [7:0]   data_byte_s1;
	logic         advance;
	logic         slot_free;
	logic         has_result;
	tgad_ctrl_t   ctrl;
	tgad_result_t result;
	tgad_result_t result_q;

	// channel byte order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= SWAP_RESET;
		end else if (cfg_we) begin
			swap_q <= cfg_wdata;
		end
	end

	// stage-1 byte retires unless it has a result and the result slot is blocked
	assign advance         = ~has_result | slot_free;
	assign ctrl.fire       = valid_s1 & advance;
	assign ctrl.has_result = has_result;

	tgad_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.file_start    (file_start),
		.data_byte     (data_byte),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.file_start_s1 (file_start_s1),
		.data_byte_s1  (data_byte_s1)
	);

	tgad_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.swap_to_rgb   (swap_q),
		.fire          (ctrl.fire),
		.file_start_s1 (file_start_s1),
		.data_byte_s1  (data_byte_s1),
		.has_result    (has_result),
		.result        (result)
	);

	tgad_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.result    (result),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_q  (result_q)
	);

	assign kind          = result_q.kind;
	assign error_code    = result_q.error_code;
	assign image_width   = result_q.image_width;
	assign image_height  = result_q.image_height;
	assign is_compressed = result_q.is_compressed;
	assign has_alpha     = result_q.has_alpha;
	assign chan0         = result_q.chan0;
	assign chan1         = result_q.chan1;
	assign chan2         = result_q.chan2;
	assign repeat_count  = result_q.repeat_count;
	assign image_done    = result_q.image_done;

endmodule

// File: bench/tga_decode_checker.sv
`timescale 1ns / 100ps
// Watches the decoder's byte and result channels, predicts each result and compares.
module tga_decode_checker
	import tgad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        file_start,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [1:0]  error_code,
	input  logic [15:0] image_width,
	input  logic [15:0] image_height,
	input  logic        is_compressed,
	input  logic        has_alpha,
	input  logic [7:0]  chan0,
	input  logic [7:0]  chan1,
	input  logic [7:0]  chan2,
	input  logic [7:0]  repeat_count,
	input  logic        image_done,
	output int          mismatches,
	output int          waiting,
	output int          checked
);

	// predictor copy of the decoder state
	logic        swap_rgb;
	phase_t      ph;
	logic [4:0]  pos;
	logic        rle;
	logic [15:0] wd;
	logic [15:0] ht;
	logic        alpha_bytes;
	logic [31:0] px_left;
	logic        pkt_raw;
	logic [7:0]  pkt_left;
	logic [23:0] colour;

	tgad_result_t expected_items[$];

	function automatic tgad_result_t error_item(input err_t code);
		tgad_result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		return r;
	endfunction

	function automatic tgad_result_t colour_item(input logic [7:0] count, input logic done);
		tgad_result_t r;
		r = '0;
		r.kind = KIND_PIXEL;
		r.chan0 = swap_rgb ? colour[23:16] : colour[7:0];
		r.chan1 = colour[15:8];
		r.chan2 = swap_rgb ? colour[7:0] : colour[23:16];
		r.repeat_count = count;
		r.image_done = done;
		return r;
	endfunction

	function automatic string show(input tgad_result_t r);
		return $sformatf("kind=%0d err=%0d w=%0d h=%0d rle=%0d alpha=%0d ch=%02x,%02x,%02x n=%0d done=%0d",
			r.kind, r.error_code, r.image_width, r.image_height, r.is_compressed,
			r.has_alpha, r.chan0, r.chan1, r.chan2, r.repeat_count, r.image_done);
	endfunction

	task automatic decode_tga_byte(input logic start, input logic [7:0] b,
			output bit emits, output tgad_result_t r);
		logic [4:0] idx;
		emits = 0;
		r = '0;
		if (start) begin
			ph = PH_HEADER;
			pos = '0;
			rle = 0;
			wd = '0;
			ht = '0;
			alpha_bytes = 0;
			px_left = '0;
			pkt_raw = 0;
			pkt_left = '0;
			colour = '0;
		end
		case (ph)
			PH_HEADER: begin
				idx = pos;
				pos = pos + 5'd1;
				if (idx == HDR_TYPE_IDX) begin
					if (b == TGA_TYPE_RAW) rle = 0;
					else if (b == TGA_TYPE_RLE) rle = 1;
					else begin
						ph = PH_ERROR;
						emits = 1;
						r = error_item(ERR_HEADER);
					end
				end else if (idx < HDR_FIX_LEN) begin
					if (b != 8'd0) begin
						ph = PH_ERROR;
						emits = 1;
						r = error_item(ERR_HEADER);
					end
				end else if (idx == HDR_W_LO) wd[7:0] = b;
				else if (idx == HDR_W_HI) wd[15:8] = b;
				else if (idx == HDR_H_LO) ht[7:0] = b;
				else if (idx == HDR_H_HI) ht[15:8] = b;
				else if (idx == HDR_BPP) colour = {16'd0, b};
				else begin
					// descriptor byte: header is judged here
					emits = 1;
					if (wd == 16'd0 || ht == 16'd0
							|| (colour[7:0] != BPP_24 && colour[7:0] != BPP_32)) begin
						ph = PH_ERROR;
						r = error_item(ERR_SIZE);
					end else begin
						alpha_bytes = (colour[7:0] == BPP_32);
						px_left = {16'd0, wd} * {16'd0, ht};
						colour = '0;
						pos = '0;
						pkt_left = '0;
						pkt_raw = 0;
						ph = rle ? PH_PACKET : PH_PIXEL;
						r.kind = KIND_HEADER;
						r.image_width = wd;
						r.image_height = ht;
						r.is_compressed = rle;
						r.has_alpha = alpha_bytes;
					end
				end
			end
			PH_PACKET: begin
				if (b < RUN_FLAG) begin
					pkt_raw = 1;
					pkt_left = b + 8'd1;
				end else begin
					pkt_raw = 0;
					pkt_left = b - RUN_BIAS;
				end
				pos = '0;
				ph = PH_PIXEL;
			end
			PH_PIXEL: begin
				idx = pos;
				if (idx < 5'd3) colour[8*idx +: 8] = b;
				if (idx < (alpha_bytes ? 5'd3 : 5'd2)) pos = idx + 5'd1;
				else begin
					pos = '0;
					emits = 1;
					if (!rle) begin
						if (px_left == 0) begin
							ph = PH_ERROR;
							r = error_item(ERR_OVERFLOW);
						end else begin
							px_left = px_left - 1;
							if (px_left == 0) ph = PH_DONE;
							r = colour_item(8'd1, px_left == 0);
						end
					end else if (pkt_raw) begin
						if (px_left == 0) begin
							ph = PH_ERROR;
							r = error_item(ERR_OVERFLOW);
						end else begin
							px_left = px_left - 1;
							pkt_left = pkt_left - 8'd1;
							if (pkt_left == 8'd0) ph = (px_left == 0) ? PH_DONE : PH_PACKET;
							r = colour_item(8'd1, px_left == 0 && pkt_left == 8'd0);
						end
					end else begin
						// one run packet carries its whole count in one item
						if ({24'd0, pkt_left} > px_left) begin
							ph = PH_ERROR;
							r = error_item(ERR_OVERFLOW);
						end else begin
							px_left = px_left - {24'd0, pkt_left};
							r = colour_item(pkt_left, px_left == 0);
							pkt_left = '0;
							ph = (px_left == 0) ? PH_DONE : PH_PACKET;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		bit emits;
		tgad_result_t r;
		tgad_result_t got;
		tgad_result_t exp_r;
		if (!arst_n) begin
			swap_rgb = SWAP_RESET;
			ph = PH_IDLE;
			pos = '0;
			rle = 0;
			wd = '0;
			ht = '0;
			alpha_bytes = 0;
			px_left = '0;
			pkt_raw = 0;
			pkt_left = '0;
			colour = '0;
			expected_items.delete();
			mismatches = 0;
			waiting = 0;
			checked = 0;
		end else begin
			// results first: nothing accepted at this edge can come out at it
			if (out_valid && !out_stall) begin
				got = {kind, error_code, image_width, image_height, is_compressed, has_alpha,
					chan0, chan1, chan2, repeat_count, image_done};
				if (expected_items.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%t: unexpected item: %s", $realtime, show(got));
				end else begin
					exp_r = expected_items.pop_front();
					checked++;
					if (got.kind !== exp_r.kind || got.error_code !== exp_r.error_code
							|| got.image_width !== exp_r.image_width
							|| got.image_height !== exp_r.image_height
							|| got.is_compressed !== exp_r.is_compressed
							|| got.has_alpha !== exp_r.has_alpha
							|| got.chan0 !== exp_r.chan0 || got.chan1 !== exp_r.chan1
							|| got.chan2 !== exp_r.chan2
							|| got.repeat_count !== exp_r.repeat_count
							|| got.image_done !== exp_r.image_done) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%t: item %0d mismatch", $realtime, checked);
							$display("  expected %s", show(exp_r));
							$display("  actual   %s", show(got));
						end
					end
				end
			end
			if (cfg_we) swap_rgb = cfg_wdata;
			if (in_valid && !in_stall) begin
				decode_tga_byte(file_start, data_byte, emits, r);
				if (emits) expected_items.push_back(r);
			end
			waiting = expected_items.size();
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Bench top: byte-stream stimulus, idling, swap register writes and verdict for the decoder.
module tb_top
	import tgad_pkg::*;
();

	// A long quiet stretch can only come from the receiver hold or from random
	// stalls/gaps; anything past this is a hang.
	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 120;
	localparam int RANDOM_BYTES = 450;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic        file_start = 1'b0;
	logic [7:0]  data_byte = 8'd0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  kind;
	logic [1:0]  error_code;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        is_compressed;
	logic        has_alpha;
	logic [7:0]  chan0;
	logic [7:0]  chan1;
	logic [7:0]  chan2;
	logic [7:0]  repeat_count;
	logic        image_done;

	int mismatches;
	int waiting;
	int checked;

	// idle rates for each side, in percent
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	// receiver hold-off: stimulus bumps the request, the receiver counts the cycles
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int bytes_sent = 0;
	int streams_sent = 0;

	typedef struct packed {
		logic       start;
		logic [7:0] b;
	} stream_byte_t;

	stream_byte_t file_q[$];

	always #2 clk = ~clk;

	tga_image_stream_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.file_start    (file_start),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.error_code    (error_code),
		.image_width   (image_width),
		.image_height  (image_height),
		.is_compressed (is_compressed),
		.has_alpha     (has_alpha),
		.chan0         (chan0),
		.chan1         (chan1),
		.chan2         (chan2),
		.repeat_count  (repeat_count),
		.image_done    (image_done)
	);

	tga_decode_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.file_start    (file_start),
		.data_byte     (data_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.error_code    (error_code),
		.image_width   (image_width),
		.image_height  (image_height),
		.is_compressed (is_compressed),
		.has_alpha     (has_alpha),
		.chan0         (chan0),
		.chan1         (chan1),
		.chan2         (chan2),
		.repeat_count  (repeat_count),
		.image_done    (image_done),
		.mismatches    (mismatches),
		.waiting       (waiting),
		.checked       (checked)
	);

	// Receiver: random stall at the current rate, or a long hold when one is requested.
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	// Watchdog: cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb_top: no progress for %0d cycles", QUIET_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	task automatic queue_byte(input logic s, input logic [7:0] b);
		file_q.push_back({s, b});
	endtask

	// 18-byte header; the descriptor byte is don't-care, so it gets random bits
	task automatic queue_header(input logic [7:0] img_type, input logic [15:0] w,
			input logic [15:0] h, input logic [7:0] bpp);
		queue_byte(1'b1, 8'd0);
		queue_byte(1'b0, 8'd0);
		queue_byte(1'b0, img_type);
		repeat (9) queue_byte(1'b0, 8'd0);
		queue_byte(1'b0, w[7:0]);
		queue_byte(1'b0, w[15:8]);
		queue_byte(1'b0, h[7:0]);
		queue_byte(1'b0, h[15:8]);
		queue_byte(1'b0, bpp);
		queue_byte(1'b0, 8'($urandom_range(255)));
	endtask

	task automatic queue_pixel(input logic four, input logic [23:0] c);
		queue_byte(1'b0, c[7:0]);
		queue_byte(1'b0, c[15:8]);
		queue_byte(1'b0, c[23:16]);
		if (four) queue_byte(1'b0, 8'($urandom_range(255)));
	endtask

	// Packets covering exactly px pixels: mostly runs, short raw packets between.
	task automatic queue_packets(input logic four, input int px);
		int n;
		while (px > 0) begin
			if ($urandom_range(2) != 0) begin
				n = $urandom_range(px < 128 ? px : 128, 1);
				queue_byte(1'b0, RUN_BIAS + 8'(n));
				queue_pixel(four, 24'($urandom));
			end else begin
				n = $urandom_range(px < 4 ? px : 4, 1);
				queue_byte(1'b0, 8'(n - 1));
				repeat (n) queue_pixel(four, 24'($urandom));
			end
			px -= n;
		end
	endtask

	// One byte item; the sender may idle first, with junk on the payload while invalid.
	task automatic send_item(input logic s, input logic [7:0] b);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			file_start <= 1'($urandom_range(1));
			data_byte <= 8'($urandom_range(255));
			@(posedge clk);
		end
		in_valid <= 1'b1;
		file_start <= s;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_stream();
		foreach (file_q[i]) send_item(file_q[i].start, file_q[i].b);
		file_q.delete();
		streams_sent++;
	endtask

	// Drain all expected items, then give a byte that made no item time to clear.
	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_swap(input logic v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_stream();
		int pick;
		int px;
		int n;
		int cut;
		logic [15:0] w;
		logic [15:0] h;
		logic rle;
		logic four;
		logic [7:0] img_type;
		logic [7:0] bpp;
		pick = $urandom_range(99);
		rle = 1'($urandom_range(1));
		four = 1'($urandom_range(1));
		img_type = rle ? TGA_TYPE_RLE : TGA_TYPE_RAW;
		bpp = four ? BPP_32 : BPP_24;
		w = 16'($urandom_range(4, 1));
		h = 16'($urandom_range(3, 1));
		if (pick < 65) begin
			// well-formed image, sometimes a wide run-length one, maybe junk after the end
			if (rle && $urandom_range(3) == 0) begin
				w = 16'($urandom_range(300, 1));
				h = 16'($urandom_range(2, 1));
			end
			queue_header(img_type, w, h, bpp);
			px = w * h;
			if (rle) queue_packets(four, px);
			else repeat (px) queue_pixel(four, 24'($urandom));
			repeat ($urandom_range(2)) queue_byte(1'b0, 8'($urandom_range(255)));
		end else if (pick < 75) begin
			// random dimensions, cut short anywhere; the next start restarts the parser
			queue_header(img_type, 16'($urandom), 16'($urandom), bpp);
			repeat ($urandom_range(12)) queue_byte(1'b0, 8'($urandom_range(255)));
			cut = $urandom_range(file_q.size(), 1);
			while (file_q.size() > cut) void'(file_q.pop_back());
		end else if (pick < 85) begin
			// run-length image whose last packet overruns the pixel count
			queue_header(TGA_TYPE_RLE, w, h, bpp);
			px = w * h;
			cut = $urandom_range(px - 1, 0);
			queue_packets(four, cut);
			n = px - cut + $urandom_range(4, 1);
			if ($urandom_range(1)) begin
				queue_byte(1'b0, RUN_BIAS + 8'(n));
				queue_pixel(four, 24'($urandom));
			end else begin
				queue_byte(1'b0, 8'(n - 1));
				repeat (n) queue_pixel(four, 24'($urandom));
			end
		end else if (pick < 93) begin
			// broken header: fixed pattern, zero size or odd depth
			queue_header(img_type, w, h, bpp);
			case ($urandom_range(3))
				0: begin
					n = $urandom_range(11);
					file_q[n].b = file_q[n].b ^ 8'($urandom_range(255, 1));
				end
				1: begin
					file_q[HDR_W_LO].b = 8'd0;
					file_q[HDR_W_HI].b = 8'd0;
				end
				2: begin
					file_q[HDR_H_LO].b = 8'd0;
					file_q[HDR_H_HI].b = 8'd0;
				end
				default: file_q[HDR_BPP].b = 8'($urandom_range(255));
			endcase
			repeat ($urandom_range(6)) queue_byte(1'b0, 8'($urandom_range(255)));
		end else begin
			// noise with the odd start flag
			repeat ($urandom_range(8, 1))
				queue_byte(1'($urandom_range(3) == 0), 8'($urandom_range(255)));
		end
		send_stream();
	endtask

	initial begin
		int target;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, swap at its reset value first ----
		in_idle_pct = 20;
		out_stall_pct = 20;
		// bytes with no start in idle are dropped
		queue_byte(1'b0, 8'hA5);
		queue_byte(1'b0, 8'h5A);
		send_stream();
		// header mismatch at the very first byte
		queue_byte(1'b1, 8'h01);
		send_stream();
		// unknown image type
		queue_byte(1'b1, 8'd0);
		queue_byte(1'b0, 8'd0);
		queue_byte(1'b0, 8'd3);
		send_stream();
		// last byte of the fixed pattern wrong
		queue_header(TGA_TYPE_RAW, 16'd1, 16'd1, BPP_24);
		file_q[HDR_FIX_LEN - 1].b = 8'hFF;
		send_stream();
		// size and depth rejects, reported at the descriptor byte
		queue_header(TGA_TYPE_RAW, 16'd0, 16'd5, BPP_24);
		send_stream();
		queue_header(TGA_TYPE_RLE, 16'd7, 16'd0, BPP_32);
		send_stream();
		queue_header(TGA_TYPE_RAW, 16'd1, 16'd1, 8'd16);
		send_stream();
		queue_header(TGA_TYPE_RLE, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_stream();
		// plain 24 bpp, extremes of the colour bytes, trailing byte ignored
		queue_header(TGA_TYPE_RAW, 16'd2, 16'd1, BPP_24);
		queue_pixel(1'b0, 24'h000000);
		queue_pixel(1'b0, 24'hFFFFFF);
		queue_byte(1'b0, 8'h77);
		send_stream();
		// plain 32 bpp, alpha dropped
		queue_header(TGA_TYPE_RAW, 16'd1, 16'd2, BPP_32);
		queue_pixel(1'b1, 24'h123456);
		queue_pixel(1'b1, 24'hABCDEF);
		send_stream();
		// run-length: a run of three then a raw packet of three
		queue_header(TGA_TYPE_RLE, 16'd3, 16'd2, BPP_24);
		queue_byte(1'b0, RUN_BIAS + 8'd3);
		queue_pixel(1'b0, 24'hC0FFEE);
		queue_byte(1'b0, 8'd2);
		repeat (3) queue_pixel(1'b0, 24'($urandom));
		send_stream();

		set_swap(1'b0);
		// longest run packet, exactly filling the image
		queue_header(TGA_TYPE_RLE, 16'd128, 16'd1, BPP_32);
		queue_byte(1'b0, RUN_BIAS + 8'd128);
		queue_pixel(1'b1, 24'h80FF01);
		send_stream();
		// longest raw packet
		queue_header(TGA_TYPE_RLE, 16'd128, 16'd1, BPP_24);
		queue_byte(1'b0, RUN_FLAG - 8'd1);
		repeat (128) queue_pixel(1'b0, 24'($urandom));
		send_stream();
		// run longer than the pixels left
		queue_header(TGA_TYPE_RLE, 16'd2, 16'd1, BPP_24);
		queue_byte(1'b0, RUN_BIAS + 8'd128);
		queue_pixel(1'b0, 24'h010203);
		send_stream();
		// raw packet longer than the image: one pixel, then too many pixels
		queue_header(TGA_TYPE_RLE, 16'd1, 16'd1, BPP_24);
		queue_byte(1'b0, 8'd1);
		queue_pixel(1'b0, 24'h445566);
		queue_pixel(1'b0, 24'h778899);
		send_stream();
		// largest image, then a new start in the middle of a pixel
		queue_header(TGA_TYPE_RAW, 16'hFFFF, 16'hFFFF, BPP_32);
		queue_pixel(1'b1, 24'hFFFFFF);
		queue_byte(1'b0, 8'd0);
		queue_header(TGA_TYPE_RAW, 16'd1, 16'd1, BPP_24);
		queue_pixel(1'b0, 24'h0F0F0F);
		queue_byte(1'b0, 8'h55);
		send_stream();

		// ---- random part: three idling patterns, swap toggled between them ----
		set_swap(1'b1);
		in_idle_pct = 29;
		out_stall_pct = 56;
		target = bytes_sent + RANDOM_BYTES / 3;
		while (bytes_sent < target) random_stream();

		set_swap(1'b0);
		in_idle_pct = 56;
		out_stall_pct = 29;
		target = bytes_sent + RANDOM_BYTES / 3;
		while (bytes_sent < target) random_stream();

		set_swap(1'b1);
		in_idle_pct = 0;
		out_stall_pct = 0;
		// receiver holds off while a dense plain image keeps coming: input must back up
		hold_req++;
		queue_header(TGA_TYPE_RAW, 16'd8, 16'd4, BPP_24);
		repeat (32) queue_pixel(1'b0, 24'($urandom));
		send_stream();
		target = bytes_sent + RANDOM_BYTES / 3;
		while (bytes_sent < target) random_stream();

		drain();
		repeat (8) @(posedge clk);
		$display("tb_top: %0d bytes in %0d streams, %0d decoded items checked", bytes_sent,
			streams_sent, checked);
		$display("tb_top: both channel orders, idling on each side in turn and a long receiver hold");
		if (mismatches == 0 && waiting == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

// File: files.f
src/tgad_pkg.sv
src/tgad_in_stage.sv
src/tgad_parser.sv
src/tgad_out_stage.sv
src/tga_image_stream_decoder_top.sv
bench/tga_decode_checker.sv
bench/tb_top.sv
